### rtl/core/vdid_pkg.sv
// ============================================================================
// vdid_pkg
// Shared types and codes for the vector DSP instruction decoder.
// ============================================================================
package vdid_pkg;

    // Field widths of the decode word.
    localparam int unsigned WORD_W = 32;
    localparam int unsigned NUM_W  = 7;
    localparam int unsigned GRP_W  = 4;

    typedef logic [NUM_W-1:0] instr_num_t;
    typedef logic [GRP_W-1:0] exec_group_t;

    // Execution groups.
    localparam exec_group_t GRP_LOAD    = 4'd0;
    localparam exec_group_t GRP_STORE   = 4'd1;
    localparam exec_group_t GRP_ALUI    = 4'd2;
    localparam exec_group_t GRP_ALUR    = 4'd3;
    localparam exec_group_t GRP_SHIFT   = 4'd4;
    localparam exec_group_t GRP_JUMP    = 4'd5;
    localparam exec_group_t GRP_BRANCH  = 4'd6;
    localparam exec_group_t GRP_COP0    = 4'd7;
    localparam exec_group_t GRP_BREAK   = 4'd8;
    localparam exec_group_t GRP_VLS     = 4'd9;
    localparam exec_group_t GRP_COP2MV  = 4'd10;
    localparam exec_group_t GRP_LANE    = 4'd11;
    localparam exec_group_t GRP_COMPUTE = 4'd12;
    localparam exec_group_t GRP_SELECT  = 4'd13;

    // Largest legal codes.
    localparam instr_num_t  NUM_MAX = 7'd121;
    localparam exec_group_t GRP_MAX = GRP_SELECT;

    // Dispatching primary opcodes.
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_COP2    = 6'h12;
    localparam logic [5:0] OP_VLOAD   = 6'h32;
    localparam logic [5:0] OP_VSTORE  = 6'h3A;

    // Decoded result.
    typedef struct packed {
        instr_num_t  num;
        exec_group_t grp;
        logic        is_vector;
        logic        illegal;
    } dec_result_t;

endpackage

### rtl/core/vdid_decode.sv
// ============================================================================
// vdid_decode
// Combinational decode of one instruction word into number, group and flags.
// ============================================================================
module vdid_decode
(
    input  logic [31:0]          word,
    output vdid_pkg::dec_result_t result
);
    import vdid_pkg::*;

    logic [5:0]  op;
    logic [5:0]  funct;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  vsel;
    logic        hit;
    instr_num_t  num;
    exec_group_t grp;

    assign op    = word[31:26];
    assign funct = word[5:0];
    assign rs    = word[25:21];
    assign rt    = word[20:16];
    assign vsel  = word[15:11];

    always_comb
    begin
        hit = 1'b1;
        num = '0;
        grp = GRP_LOAD;
        case (op)
            OP_SPECIAL:
            begin
                grp = GRP_ALUR;
                case (funct)
                    6'h20: num = 7'd0;
                    6'h21: num = 7'd1;
                    6'h24: num = 7'd2;
                    6'h27: num = 7'd3;
                    6'h25: num = 7'd4;
                    6'h2A: num = 7'd5;
                    6'h2B: num = 7'd6;
                    6'h22: num = 7'd7;
                    6'h23: num = 7'd8;
                    6'h26: num = 7'd9;
                    6'h00: begin num = 7'd10; grp = GRP_SHIFT; end
                    6'h04: begin num = 7'd11; grp = GRP_SHIFT; end
                    6'h03: begin num = 7'd12; grp = GRP_SHIFT; end
                    6'h07: begin num = 7'd13; grp = GRP_SHIFT; end
                    6'h02: begin num = 7'd14; grp = GRP_SHIFT; end
                    6'h06: begin num = 7'd15; grp = GRP_SHIFT; end
                    6'h09: begin num = 7'd16; grp = GRP_JUMP;  end
                    6'h08: begin num = 7'd17; grp = GRP_JUMP;  end
                    6'h0D: begin num = 7'd18; grp = GRP_BREAK; end
                    default: hit = 1'b0;
                endcase
            end
            OP_REGIMM:
            begin
                grp = GRP_BRANCH;
                case (rt)
                    5'h01: num = 7'd19;
                    5'h11: num = 7'd20;
                    5'h00: num = 7'd21;
                    5'h10: num = 7'd22;
                    default: hit = 1'b0;
                endcase
            end
            OP_COP0:
            begin
                grp = GRP_COP0;
                case (rs)
                    5'h00: num = 7'd23;
                    5'h04: num = 7'd24;
                    default: hit = 1'b0;
                endcase
            end
            OP_COP2:
            begin
                if (word[25])
                begin
                    // vector compute, dense by funct range
                    grp = GRP_COMPUTE;
                    if (funct <= 6'h11)
                    begin
                        num = 7'd25 + 7'(funct);
                        if (funct == 6'h02 || funct == 6'h0A)
                        begin
                            grp = GRP_LANE;
                        end
                    end
                    else if (funct >= 6'h13 && funct <= 6'h15)
                    begin
                        num = 7'd43 + 7'(funct - 6'h13);
                    end
                    else if (funct == 6'h1D)
                    begin
                        num = 7'd46;
                    end
                    else if (funct >= 6'h20 && funct <= 6'h2D)
                    begin
                        num = 7'd47 + 7'(funct - 6'h20);
                        if (funct <= 6'h27)
                        begin
                            grp = GRP_SELECT;
                        end
                    end
                    else if (funct >= 6'h30 && funct <= 6'h37)
                    begin
                        num = 7'd61 + 7'(funct - 6'h30);
                        grp = GRP_LANE;
                    end
                    else
                    begin
                        hit = 1'b0;
                    end
                end
                else
                begin
                    grp = GRP_COP2MV;
                    case (rs)
                        5'h00: num = 7'd69;
                        5'h04: num = 7'd70;
                        5'h02: num = 7'd71;
                        5'h06: num = 7'd72;
                        default: hit = 1'b0;
                    endcase
                end
            end
            OP_VLOAD:
            begin
                grp = GRP_VLS;
                num = 7'd98 + 7'(vsel);
                hit = (vsel < 5'd12);
            end
            OP_VSTORE:
            begin
                grp = GRP_VLS;
                num = 7'd110 + 7'(vsel);
                hit = (vsel < 5'd12);
            end
            6'h20: num = 7'd73;
            6'h24: num = 7'd74;
            6'h21: num = 7'd75;
            6'h25: num = 7'd76;
            6'h30: num = 7'd77;
            6'h23: num = 7'd78;
            6'h27: num = 7'd79;
            6'h28: begin num = 7'd80; grp = GRP_STORE;  end
            6'h38: begin num = 7'd81; grp = GRP_STORE;  end
            6'h29: begin num = 7'd82; grp = GRP_STORE;  end
            6'h2B: begin num = 7'd83; grp = GRP_STORE;  end
            6'h08: begin num = 7'd84; grp = GRP_ALUI;   end
            6'h09: begin num = 7'd85; grp = GRP_ALUI;   end
            6'h0C: begin num = 7'd86; grp = GRP_ALUI;   end
            6'h0F: begin num = 7'd87; grp = GRP_ALUI;   end
            6'h0D: begin num = 7'd88; grp = GRP_ALUI;   end
            6'h0A: begin num = 7'd89; grp = GRP_ALUI;   end
            6'h0B: begin num = 7'd90; grp = GRP_ALUI;   end
            6'h0E: begin num = 7'd91; grp = GRP_ALUI;   end
            6'h02: begin num = 7'd92; grp = GRP_JUMP;   end
            6'h03: begin num = 7'd93; grp = GRP_JUMP;   end
            6'h04: begin num = 7'd94; grp = GRP_BRANCH; end
            6'h07: begin num = 7'd95; grp = GRP_BRANCH; end
            6'h06: begin num = 7'd96; grp = GRP_BRANCH; end
            6'h05: begin num = 7'd97; grp = GRP_BRANCH; end
            default: hit = 1'b0;
        endcase
    end

    // Unlisted encodings report zero number and group.
    always_comb
    begin
        if (hit)
        begin
            result.num       = num;
            result.grp       = grp;
            result.is_vector = (grp >= GRP_VLS);
            result.illegal   = 1'b0;
        end
        else
        begin
            result.num       = '0;
            result.grp       = GRP_LOAD;
            result.is_vector = 1'b0;
            result.illegal   = 1'b1;
        end
    end

endmodule

### rtl/core/vector_dsp_instruction_decoder_core.sv
// ============================================================================
// vector_dsp_instruction_decoder_core
// Two-register decode pipeline: input word register, decode, result register.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | sink      | in_valid/in_stall  | instruction_word[31:0]
//  out     | source    | out_valid/out_stall| instruction_number[6:0],
//          |           |                    | execution_group[3:0], is_vector, illegal
//
//  One word per clock sustained while out_stall stays low; an accepted word
//  is held in the input register, decoded, then loaded into the result register.
//  The input register and the result register each hold one word,
//  so a stalled result still lets one more word in. rst_n clears both valid
//  flags asynchronously; payload registers are not reset. in_stall rises
//  only when both registers are full and out_stall is high.
//
module vector_dsp_instruction_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instruction_word,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  instruction_number,
    output logic [3:0]  execution_group,
    output logic        is_vector,
    output logic        illegal
);
    import vdid_pkg::*;

    logic        word_valid_reg;
    logic [31:0] word_reg;
    logic        res_valid_reg;
    dec_result_t res_reg;
    dec_result_t dec_next;

    logic        res_load;    // result register can take a word this cycle
    logic        word_move;   // input register hands its word on
    logic        in_take;     // input handshake completes

    assign res_load  = !res_valid_reg || !out_stall;
    assign word_move = word_valid_reg && res_load;
    assign in_stall  = word_valid_reg && !res_load;
    assign in_take   = in_valid && !in_stall;

    // Decode sits between the two registers.
    vdid_decode u_decode
    (
        .word   (word_reg),
        .result (dec_next)
    );

    // Input stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            word_valid_reg <= 1'b1;
        end
        else if (word_move)
        begin
            word_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            word_reg <= instruction_word;
        end
    end

    // Result stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= word_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_move)
        begin
            res_reg <= dec_next;
        end
    end

    assign out_valid          = res_valid_reg;
    assign instruction_number = res_reg.num;
    assign execution_group    = res_reg.grp;
    assign is_vector          = res_reg.is_vector;
    assign illegal            = res_reg.illegal;

endmodule

### rtl/core/vdid_checker.sv
// ============================================================================
// vdid_checker
// Port-level checks for the instruction decoder, bound to the top level.
// ============================================================================
module vdid_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [6:0]  instruction_number,
    input logic [3:0]  execution_group,
    input logic        is_vector,
    input logic        illegal
);
    import vdid_pkg::*;

    // Held result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(instruction_number)
            && $stable(execution_group) && $stable(is_vector) && $stable(illegal))
        else $error("result changed while stalled");

    // Empty output side never backs up the input.
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

    a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && illegal |-> instruction_number == '0
            && execution_group == GRP_LOAD && !is_vector)
        else $error("illegal word carries nonzero fields");

    a_vector_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !illegal |-> is_vector == (execution_group >= GRP_VLS)
            && instruction_number <= NUM_MAX && execution_group <= GRP_MAX)
        else $error("vector flag or code range wrong");

endmodule

bind vector_dsp_instruction_decoder_core vdid_checker u_vdid_checker (.*);

### sim/decode_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// decode_checker
// Watches both channels of the decoder, predicts the decode of every accepted
// word and compares it field by field with the words that come out.
// ============================================================================
module decode_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] instruction_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [6:0]  instruction_number,
    input  logic [3:0]  execution_group,
    input  logic        is_vector,
    input  logic        illegal,
    output int          error_count,
    output int          pending_count,
    output int          checked_count,
    output int          illegal_count,
    output int          vector_count
);

    import vdid_pkg::*;

    // First instruction number of each decode stage.
    localparam int SPECIAL_BASE = 0;
    localparam int REGIMM_BASE  = 19;
    localparam int COP0_BASE    = 23;
    localparam int COMPUTE_BASE = 25;
    localparam int MOVE_BASE    = 69;
    localparam int PRIMARY_BASE = 73;
    localparam int VLOAD_BASE   = 98;
    localparam int VSTORE_BASE  = 110;
    localparam int VLS_COUNT    = 12;
    localparam int COP2_COMPUTE_BIT = 25;

    // Decode tables, index = offset from the stage base.
    localparam logic [0:18][5:0] SPECIAL_FUNCTS = {
        6'h20, 6'h21, 6'h24, 6'h27, 6'h25, 6'h2A, 6'h2B, 6'h22, 6'h23, 6'h26,
        6'h00, 6'h04, 6'h03, 6'h07, 6'h02, 6'h06, 6'h09, 6'h08, 6'h0D};
    localparam logic [0:18][3:0] SPECIAL_GROUPS = {
        {10{GRP_ALUR}}, {6{GRP_SHIFT}}, {2{GRP_JUMP}}, GRP_BREAK};
    localparam logic [0:3][4:0] REGIMM_RTS = {5'h01, 5'h11, 5'h00, 5'h10};
    localparam logic [0:1][4:0] COP0_RS    = {5'h00, 5'h04};
    localparam logic [0:3][4:0] MOVE_RS    = {5'h00, 5'h04, 5'h02, 5'h06};
    localparam logic [0:24][5:0] PRIMARY_OPS = {
        6'h20, 6'h24, 6'h21, 6'h25, 6'h30, 6'h23, 6'h27,
        6'h28, 6'h38, 6'h29, 6'h2B,
        6'h08, 6'h09, 6'h0C, 6'h0F, 6'h0D, 6'h0A, 6'h0B, 6'h0E,
        6'h02, 6'h03,
        6'h04, 6'h07, 6'h06, 6'h05};
    localparam logic [0:24][3:0] PRIMARY_GROUPS = {
        {7{GRP_LOAD}}, {4{GRP_STORE}}, {8{GRP_ALUI}}, {2{GRP_JUMP}}, {4{GRP_BRANCH}}};

    // Vector compute functs: bit n set = funct n is listed. Numbers run densely
    // over the listed functs in ascending order.
    localparam logic [63:0] COMPUTE_LISTED = 64'h00FF_3FFF_203B_FFFF;
    localparam logic [63:0] COMPUTE_LANE   = 64'h00FF_0000_0000_0404;
    localparam logic [63:0] COMPUTE_SELECT = 64'h0000_00FF_0000_0000;

    typedef struct packed {
        logic [31:0] word;
        dec_result_t result;
    } pending_decode_t;

    pending_decode_t expected_decodes[$];

    function automatic dec_result_t decode_word(input logic [31:0] w);
        logic [5:0]  op;
        logic [5:0]  funct;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  vsel;
        int          num;
        exec_group_t grp;
        dec_result_t r;
        op    = w[31:26];
        funct = w[5:0];
        rs    = w[25:21];
        rt    = w[20:16];
        vsel  = w[15:11];
        num   = -1;
        grp   = GRP_LOAD;
        case (op)
            OP_SPECIAL:
            begin
                for (int i = 0; i < 19; i++)
                    if (SPECIAL_FUNCTS[i] == funct)
                    begin
                        num = SPECIAL_BASE + i;
                        grp = SPECIAL_GROUPS[i];
                    end
            end
            OP_REGIMM:
            begin
                grp = GRP_BRANCH;
                for (int i = 0; i < 4; i++)
                    if (REGIMM_RTS[i] == rt)
                        num = REGIMM_BASE + i;
            end
            OP_COP0:
            begin
                grp = GRP_COP0;
                for (int i = 0; i < 2; i++)
                    if (COP0_RS[i] == rs)
                        num = COP0_BASE + i;
            end
            OP_COP2:
            begin
                if (w[COP2_COMPUTE_BIT])
                begin
                    if (COMPUTE_LISTED[funct])
                    begin
                        num = COMPUTE_BASE;
                        for (int i = 0; i < funct; i++)
                            num += COMPUTE_LISTED[i];
                        if (COMPUTE_LANE[funct])
                            grp = GRP_LANE;
                        else if (COMPUTE_SELECT[funct])
                            grp = GRP_SELECT;
                        else
                            grp = GRP_COMPUTE;
                    end
                end
                else
                begin
                    grp = GRP_COP2MV;
                    for (int i = 0; i < 4; i++)
                        if (MOVE_RS[i] == rs)
                            num = MOVE_BASE + i;
                end
            end
            OP_VLOAD:
            begin
                grp = GRP_VLS;
                if (vsel < VLS_COUNT)
                    num = VLOAD_BASE + vsel;
            end
            OP_VSTORE:
            begin
                grp = GRP_VLS;
                if (vsel < VLS_COUNT)
                    num = VSTORE_BASE + vsel;
            end
            default:
            begin
                for (int i = 0; i < 25; i++)
                    if (PRIMARY_OPS[i] == op)
                    begin
                        num = PRIMARY_BASE + i;
                        grp = PRIMARY_GROUPS[i];
                    end
            end
        endcase
        r = '0;
        if (num < 0)
            r.illegal = 1'b1;
        else
        begin
            r.num       = instr_num_t'(num);
            r.grp       = grp;
            r.is_vector = (grp >= GRP_VLS);
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] word,
                                 input logic [31:0] expected, input logic [31:0] actual);
        if (expected !== actual)
        begin
            error_count++;
            $display("%0t ns: word %08h %s expected %0d, got %0d",
                     $time, word, name, expected, actual);
        end
    endtask

    initial
    begin
        error_count   = 0;
        pending_count = 0;
        checked_count = 0;
        illegal_count = 0;
        vector_count  = 0;
    end

    // Retire the outgoing word before queuing the incoming one.
    always @(posedge clk)
    begin
        pending_decode_t head;
        dec_result_t     got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {instruction_number, execution_group, is_vector, illegal};
                checked_count++;
                if (got.illegal)
                    illegal_count++;
                if (got.is_vector)
                    vector_count++;
                if (expected_decodes.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: unexpected result num %0d grp %0d vec %0d ill %0d",
                             $time, got.num, got.grp, got.is_vector, got.illegal);
                end
                else
                begin
                    head = expected_decodes.pop_front();
                    compare_field("instruction_number", head.word,
                                  32'(head.result.num), 32'(got.num));
                    compare_field("execution_group", head.word,
                                  32'(head.result.grp), 32'(got.grp));
                    compare_field("is_vector", head.word, 32'(head.result.is_vector),
                                  32'(got.is_vector));
                    compare_field("illegal", head.word, 32'(head.result.illegal),
                                  32'(got.illegal));
                end
            end
            if (in_valid && !in_stall)
            begin
                head.word   = instruction_word;
                head.result = decode_word(instruction_word);
                expected_decodes.push_back(head);
            end
            pending_count = expected_decodes.size();
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Drives instruction words into the decoder under changing idle and stall
// mixes; the checker beside the block predicts and compares every decode.
// ============================================================================
module testbench;

    import vdid_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 9;
    localparam int WORDS_PER_PHASE = 420;     // three phases, 1260 random words
    localparam int DRAIN_CYCLES    = 10;      // two-stage pipe, plus margin
    localparam int CYCLE_LIMIT     = 200000;  // watchdog bound
    localparam int COP2_COMPUTE_BIT = 25;

    // Shapes of random words. Noise takes the leftover draws so plain
    // random words (and all primary opcodes) show up about twice as often.
    typedef enum int {
        FORM_SPECIAL,
        FORM_REGIMM,
        FORM_COP0,
        FORM_COMPUTE,
        FORM_MOVE,
        FORM_VLOAD,
        FORM_VSTORE,
        FORM_NOISE
    } word_form_e;

    logic        clk;
    logic        rst_n            = 1'b0;
    logic        in_valid         = 1'b0;
    logic        in_stall;
    logic [31:0] instruction_word = '0;
    logic        out_valid;
    logic        out_stall        = 1'b0;
    logic [6:0]  instruction_number;
    logic [3:0]  execution_group;
    logic        is_vector;
    logic        illegal;

    int error_count;
    int pending_count;
    int checked_count;
    int illegal_count;
    int vector_count;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    vector_dsp_instruction_decoder_core uut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .instruction_word   (instruction_word),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .instruction_number (instruction_number),
        .execution_group    (execution_group),
        .is_vector          (is_vector),
        .illegal            (illegal)
    );

    decode_checker decode_check
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .instruction_word   (instruction_word),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .instruction_number (instruction_number),
        .execution_group    (execution_group),
        .is_vector          (is_vector),
        .illegal            (illegal),
        .error_count        (error_count),
        .pending_count      (pending_count),
        .checked_count      (checked_count),
        .illegal_count      (illegal_count),
        .vector_count       (vector_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still outstanding",
                     cycle_count, pending_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random back-pressure, one draw per cycle. A zero rate leaves
    // the output never stalled.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // Offer one word, with random idle cycles in front of it, and hold it
    // steady until the decoder takes it. Returns on the accepting edge, so the
    // caller's next assignment to in_valid lands in a later time step.
    task automatic send_word(input logic [31:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        instruction_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop sending and wait until every decoded word has come out. It waits on
    // the clock first, so the checker has queued the last accepted word.
    task automatic drain_pending();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // Random word biased toward the decodable forms: the selecting field is
    // steered into its listed range most of the time, while every other bit
    // stays random so the ignored fields keep toggling.
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        int          pick;
        word_form_e  form;
        w    = $urandom();
        pick = $urandom_range(int'(FORM_NOISE) + 1);
        form = (pick >= int'(FORM_NOISE)) ? FORM_NOISE : word_form_e'(pick);
        case (form)
            FORM_SPECIAL:
                w[31:26] = OP_SPECIAL;
            FORM_REGIMM:
            begin
                w[31:26] = OP_REGIMM;
                // rt with bits 3..1 clear is one of the four branch forms
                if ($urandom_range(3) != 0)
                    w[19:17] = 3'b000;
            end
            FORM_COP0:
            begin
                w[31:26] = OP_COP0;
                // rs of 0 or 4
                if ($urandom_range(3) != 0)
                begin
                    w[25:24] = 2'b00;
                    w[22:21] = 2'b00;
                end
            end
            FORM_COMPUTE:
            begin
                w[31:26] = OP_COP2;
                w[COP2_COMPUTE_BIT] = 1'b1;
            end
            FORM_MOVE:
            begin
                w[31:26] = OP_COP2;
                w[COP2_COMPUTE_BIT] = 1'b0;
                // rs of 0, 2, 4 or 6
                if ($urandom_range(3) != 0)
                begin
                    w[24] = 1'b0;
                    w[21] = 1'b0;
                end
            end
            FORM_VLOAD,
            FORM_VSTORE:
            begin
                w[31:26] = (form == FORM_VLOAD) ? OP_VLOAD : OP_VSTORE;
                // element select below 16, so mostly one of the twelve listed
                if ($urandom_range(3) != 0)
                    w[15] = 1'b0;
            end
            default:
            begin
            end
        endcase
        return w;
    endfunction

    initial
    begin
        // ---- reset: held for a fixed count, released once, never again ----
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed corners, under the first idle/stall mix ----
        send_idle_pct = 21;
        recv_idle_pct = 48;
        send_word(32'h0000_0000);                            // all zero: shift, number 10
        send_word(32'hFFFF_FFFF);                            // all ones: unlisted opcode
        send_word({OP_SPECIAL, 20'hFFFFF, 6'h0D});           // break, register bits set
        send_word({OP_SPECIAL, 20'h00000, 6'h3F});           // unlisted SPECIAL funct
        send_word({OP_REGIMM, 5'h1F, 5'h00, 16'hFFFF});      // each listed REGIMM rt
        send_word({OP_REGIMM, 5'h1F, 5'h01, 16'hFFFF});
        send_word({OP_REGIMM, 5'h00, 5'h10, 16'h0000});
        send_word({OP_REGIMM, 5'h00, 5'h11, 16'h0000});
        send_word({OP_REGIMM, 5'h00, 5'h1F, 16'h0000});      // unlisted rt
        send_word({OP_COP0, 5'h04, 21'h1FFFFF});             // COP0 move, top rs
        send_word({OP_COP0, 5'h1F, 21'h000000});             // unlisted COP0 rs
        send_word({OP_COP2, 1'b1, 4'hF, 15'h0000, 6'h00});   // compute, ignored rs bits set
        send_word({OP_COP2, 1'b1, 4'h0, 15'h7FFF, 6'h37});   // last lane op, number 68
        send_word({OP_COP2, 1'b1, 4'h0, 15'h0000, 6'h27});   // last select op
        send_word({OP_COP2, 1'b1, 4'h0, 15'h0000, 6'h12});   // gap in compute functs
        send_word({OP_COP2, 1'b1, 4'hF, 15'h7FFF, 6'h3F});   // top unlisted compute funct
        send_word({OP_COP2, 5'h06, 21'h1FFFFF});             // COP2 move, last listed rs
        send_word({OP_COP2, 5'h01, 21'h000000});             // unlisted move rs
        send_word({OP_VLOAD, 10'h3FF, 5'd11, 11'h7FF});      // last vector load
        send_word({OP_VLOAD, 10'h000, 5'd12, 11'h000});      // first unlisted element
        send_word({OP_VSTORE, 10'h000, 5'd0, 11'h000});      // first vector store
        send_word({OP_VSTORE, 10'h3FF, 5'd31, 11'h7FF});     // top element select
        send_word({6'h20, 26'h3FFFFFF});                     // first primary, number 73
        send_word({6'h38, 26'h0000000});                     // lone store in the 0x38 slot
        send_word({6'h05, 26'h0000000});                     // last number of the table
        // let the pipe empty completely once with the sender held off
        drain_pending();

        // ---- random words: three mixes, full drain after each ----
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 21;
                    recv_idle_pct = 48;
                end
                1:
                begin
                    send_idle_pct = 48;
                    recv_idle_pct = 21;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (WORDS_PER_PHASE)
                send_word(random_word());
            drain_pending();
        end

        // nothing should come out after the queue has emptied
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run summary: %0d words decoded and checked, %0d illegal, %0d vector-unit",
                 checked_count, illegal_count, vector_count);
        $display("Directed corners plus three idle/stall mixes, each drained to empty");
        if (error_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/core/vdid_pkg.sv
rtl/core/vdid_decode.sv
rtl/core/vector_dsp_instruction_decoder_core.sv
rtl/core/vdid_checker.sv
sim/decode_checker.sv
sim/testbench.sv
